// ----- hdl/stt_pkg.sv -----
// ---------------------------------------------------------------------------
// Sleep timeout table package
// Operation codes, result kinds and sequencer states shared by the design.
// ---------------------------------------------------------------------------
package stt_pkg;

	// Request operation codes; code 3 carries no meaning and is ignored.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SLEEP  = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_WAKE      = 2'd0,
		KIND_CANCELLED = 2'd1,
		KIND_NOT_FOUND = 2'd2,
		KIND_FULL      = 2'd3
	} kind_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_REPORT
	} state_t;

endpackage

// ----- hdl/sleep_timeout_table.sv -----
// ---------------------------------------------------------------------------
// Sleep timeout table
// Holds sleeping threads with their tick counts, newest first, counts them
// down on each tick and reports timeouts, cancels, cancels that find nothing
// and a full table.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+---------------------------------------------
//  request | req_valid, req_ready  | operation, thread_id, ticks
//  result  | rsp_valid, rsp_ready  | kind, woken_thread, remaining_ticks, last
//
// A sleep item is written as it is taken; a sleep on a full table is refused
// and reported. A tick on an empty table does nothing and a cancel on an
// empty table reports not found. Otherwise a tick or cancel item walks the
// occupied slots: one shared walk unit reads one slot a cycle from the table
// memory (one read and one write port), counts it down or matches it, and
// writes it back compacted. A result waiting on rsp_ready stalls the walk.
// The asynchronous reset empties the table at once; no clearing pass is
// needed since occupancy is kept as a base pointer and a fill count.
//
module sleep_timeout_table
	import stt_pkg::*;
#(
	parameter int SLOTS       = 16,
	parameter int TICK_BITS   = 32,
	parameter int THREAD_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [1:0]             operation,
	input  logic [THREAD_BITS-1:0] thread_id,
	input  logic [TICK_BITS-1:0]   ticks,

	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic [1:0]             kind,
	output logic [THREAD_BITS-1:0] woken_thread,
	output logic [TICK_BITS-1:0]   remaining_ticks,
	output logic                   last
);

	// Pointer, count and entry widths.
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = CW + 1;
	localparam int EW = THREAD_BITS + TICK_BITS;

	// The table is a circular buffer: base_q is the oldest entry and the
	// newest sits at base_q + count_q - 1, wrapping at SLOTS.
	logic [EW-1:0] slot_mem [SLOTS];

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [IW-1:0] base_q;
	logic [IW-1:0] rd_ptr_q;
	logic [IW-1:0] wr_ptr_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] removed_q;
	logic          is_cancel_q;
	logic          found_q;
	logic [THREAD_BITS-1:0] req_thread_q;

	// Walk pipeline: the registered memory read forms stage one.
	logic          valid_s1;
	logic [EW-1:0] rdata_s1;

	// The result waiting to be reported; it only goes out once the next one
	// is known, so that the last flag is correct.
	logic                   pend_valid_q;
	kind_t                  pend_kind_q;
	logic [THREAD_BITS-1:0] pend_thread_q;
	logic [TICK_BITS-1:0]   pend_rem_q;

	// Output register.
	logic                   rsp_valid_q;
	kind_t                  kind_q;
	logic [THREAD_BITS-1:0] woken_q;
	logic [TICK_BITS-1:0]   rem_q;
	logic                   last_q;

	// Combinational control.
	logic                   accept;
	logic                   out_free;
	logic                   table_full;
	logic [SW-1:0]          ins_sum;
	logic [SW-1:0]          new_sum;
	logic [IW-1:0]          ins_slot;
	logic [IW-1:0]          newest_slot;
	logic [THREAD_BITS-1:0] ent_thread;
	logic [TICK_BITS-1:0]   ent_rem;
	logic [TICK_BITS-1:0]   rem_dec;
	logic [TICK_BITS-1:0]   new_rem;
	logic                   walk_done;
	logic                   step;
	logic                   rd_en;
	logic                   expire;
	logic                   hit;
	logic                   drop;
	logic                   keep_wr;
	logic                   push_old;
	logic                   report_fire;
	logic                   out_load;
	logic                   insert_wr;
	logic                   mem_we;
	logic [IW-1:0]          mem_waddr;
	logic [EW-1:0]          mem_wdata;

	assign accept     = req_valid && req_ready;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign table_full = (count_q == CW'(SLOTS));

	// Slot for a new entry, and the newest slot, both modulo SLOTS.
	assign ins_sum     = SW'(base_q) + SW'(count_q);
	assign new_sum     = ins_sum - 1'b1;
	assign ins_slot    = (ins_sum >= SW'(SLOTS)) ? IW'(ins_sum - SW'(SLOTS)) : IW'(ins_sum);
	assign newest_slot = (new_sum >= SW'(SLOTS)) ? IW'(new_sum - SW'(SLOTS)) : IW'(new_sum);

	assign ent_thread = rdata_s1[EW-1:TICK_BITS];
	assign ent_rem    = rdata_s1[TICK_BITS-1:0];
	assign rem_dec    = ent_rem - 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_TICK:   state_d = (count_q != '0) ? ST_WALK : ST_IDLE;
						OP_SLEEP:  state_d = table_full ? ST_REPORT : ST_IDLE;
						OP_CANCEL: state_d = (count_q != '0) ? ST_WALK : ST_REPORT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				if (walk_done) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (!pend_valid_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer and the shared walk unit.
	always_comb begin
		req_ready   = (state_q == ST_IDLE);
		walk_done   = (state_q == ST_WALK) && (left_q == '0) && !valid_s1;
		step        = (state_q == ST_WALK) && out_free && !walk_done;
		rd_en       = step && (left_q != '0);
		expire      = valid_s1 && !is_cancel_q && (ent_rem != '0) && (rem_dec == '0);
		hit         = valid_s1 && is_cancel_q && !found_q && (ent_thread == req_thread_q);
		drop        = expire || hit;
		keep_wr     = step && valid_s1 && !drop;
		new_rem     = (!is_cancel_q && (ent_rem != '0)) ? rem_dec : ent_rem;
		push_old    = step && expire && pend_valid_q;
		report_fire = (state_q == ST_REPORT) && pend_valid_q && out_free;
		out_load    = push_old || report_fire;
		insert_wr   = accept && (operation == OP_SLEEP) && !table_full;
		mem_we      = insert_wr || keep_wr;
		mem_waddr   = insert_wr ? ins_slot : wr_ptr_q;
		mem_wdata   = insert_wr ? {thread_id, ticks} : {ent_thread, new_rem};
	end

	// Table memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= slot_mem[rd_ptr_q];
		end
	end

	// Sequencer and walk control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			base_q       <= '0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			left_q       <= '0;
			removed_q    <= '0;
			is_cancel_q  <= 1'b0;
			found_q      <= 1'b0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (accept) begin
				is_cancel_q <= (operation == OP_CANCEL);
				rd_ptr_q    <= newest_slot;
				wr_ptr_q    <= newest_slot;
				left_q      <= count_q;
				removed_q   <= '0;
				found_q     <= 1'b0;
				valid_s1    <= 1'b0;
				if (insert_wr) begin
					count_q <= count_q + 1'b1;
				end
				if ((operation == OP_SLEEP && table_full) ||
				    (operation == OP_CANCEL && count_q == '0)) begin
					pend_valid_q <= 1'b1;
				end
			end

			if (step) begin
				valid_s1 <= rd_en;
				if (rd_en) begin
					rd_ptr_q <= (rd_ptr_q == '0) ? IW'(SLOTS - 1) : rd_ptr_q - 1'b1;
					left_q   <= left_q - 1'b1;
				end
				if (keep_wr) begin
					wr_ptr_q <= (wr_ptr_q == '0) ? IW'(SLOTS - 1) : wr_ptr_q - 1'b1;
				end
				if (drop) begin
					removed_q    <= removed_q + 1'b1;
					pend_valid_q <= 1'b1;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end

			if (walk_done) begin
				base_q  <= (wr_ptr_q == IW'(SLOTS - 1)) ? '0 : wr_ptr_q + 1'b1;
				count_q <= count_q - removed_q;
				if (is_cancel_q && !found_q) begin
					pend_valid_q <= 1'b1;
				end
			end

			if (report_fire) begin
				pend_valid_q <= 1'b0;
			end

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload of the waiting result and of the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_thread_q  <= thread_id;
			pend_thread_q <= thread_id;
			pend_rem_q    <= '0;
			pend_kind_q   <= (operation == OP_SLEEP) ? KIND_FULL : KIND_NOT_FOUND;
		end
		if (step && expire) begin
			pend_kind_q   <= KIND_WAKE;
			pend_thread_q <= ent_thread;
			pend_rem_q    <= '0;
		end
		if (step && hit) begin
			pend_kind_q   <= KIND_CANCELLED;
			pend_thread_q <= ent_thread;
			pend_rem_q    <= ent_rem;
		end
		if (walk_done && is_cancel_q && !found_q) begin
			pend_kind_q   <= KIND_NOT_FOUND;
			pend_thread_q <= req_thread_q;
			pend_rem_q    <= '0;
		end
		if (out_load) begin
			kind_q  <= pend_kind_q;
			woken_q <= pend_thread_q;
			rem_q   <= pend_rem_q;
			last_q  <= report_fire;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign kind            = kind_q;
	assign woken_thread    = woken_q;
	assign remaining_ticks = rem_q;
	assign last            = last_q;

	// The fill count never exceeds the table.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("fill count beyond table size");

	// A walk never reads or removes more slots than the table holds.
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (left_q <= count_q && removed_q <= count_q))
		else $error("walk counters beyond fill count");

	// A sleep on a table with room adds exactly one entry.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && operation == OP_SLEEP && count_q != CW'(SLOTS))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the table");

	// Nothing is left waiting to be reported once the block is idle.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("result left pending in idle");

	// A cancel removes at most one entry.
	a_cancel_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && is_cancel_q) |-> (removed_q <= CW'(1)))
		else $error("cancel removed more than one entry");

endmodule

// ----- test/stt_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sleep timeout table checker
// Watches both channels of the table, keeps its own copy of the sleepers,
// works out the results each request item must cause and compares every
// result item against them in order.
// ---------------------------------------------------------------------------
module stt_checker
	import stt_pkg::*;
#(
	parameter int SLOTS       = 16,
	parameter int TICK_BITS   = 32,
	parameter int THREAD_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   req_valid,
	input  logic                   req_ready,
	input  logic [1:0]             operation,
	input  logic [THREAD_BITS-1:0] thread_id,
	input  logic [TICK_BITS-1:0]   ticks,

	input  logic                   rsp_valid,
	input  logic                   rsp_ready,
	input  logic [1:0]             kind,
	input  logic [THREAD_BITS-1:0] woken_thread,
	input  logic [TICK_BITS-1:0]   remaining_ticks,
	input  logic                   last,

	output int                     fail_count,
	output int                     pending,
	output int                     req_taken,
	output int                     rsp_taken,
	output int                     wakes_seen,
	output int                     cancels_found,
	output int                     fulls_seen
);

	typedef struct packed {
		kind_t                  what;
		logic [THREAD_BITS-1:0] tid;
		logic [TICK_BITS-1:0]   left;
		logic                   tail;
	} wake_result_t;

	// Sleepers, newest first and packed from entry 0.
	logic                   sleeper_used [SLOTS];
	logic [THREAD_BITS-1:0] sleeper_tid  [SLOTS];
	logic [TICK_BITS-1:0]   sleeper_left [SLOTS];

	wake_result_t due_results [$];

	int errors;
	int n_pend;
	int n_req;
	int n_rsp;
	int n_wake;
	int n_found;
	int n_full;

	assign fail_count    = errors;
	assign pending       = n_pend;
	assign req_taken     = n_req;
	assign rsp_taken     = n_rsp;
	assign wakes_seen    = n_wake;
	assign cancels_found = n_found;
	assign fulls_seen    = n_full;

	initial begin
		errors = 0;
	end

	task automatic report(input string msg);
		if (errors < 30) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
		errors++;
	endtask

	function automatic void drop_sleeper(input int idx);
		for (int j = idx; j + 1 < SLOTS; j++) begin
			sleeper_used[j] = sleeper_used[j+1];
			sleeper_tid[j]  = sleeper_tid[j+1];
			sleeper_left[j] = sleeper_left[j+1];
		end
		sleeper_used[SLOTS-1] = 1'b0;
	endfunction

	function automatic void push_result(input kind_t what, input logic [THREAD_BITS-1:0] tid,
			input logic [TICK_BITS-1:0] left, input logic tail);
		wake_result_t r;
		r.what = what;
		r.tid  = tid;
		r.left = left;
		r.tail = tail;
		due_results.push_back(r);
	endfunction

	// Applies one request item to the copy of the table and queues what it causes.
	task automatic step_sleep_table(input logic [1:0] op, input logic [THREAD_BITS-1:0] tid,
			input logic [TICK_BITS-1:0] tk);
		int           i;
		int           woken;
		int           occupied;
		bit           hit;
		wake_result_t r;
		i        = 0;
		woken    = 0;
		occupied = 0;
		hit      = 1'b0;
		case (op)
			OP_TICK: begin
				while (i < SLOTS) begin
					if (sleeper_used[i] && sleeper_left[i] != '0) begin
						sleeper_left[i] = sleeper_left[i] - 1'b1;
						if (sleeper_left[i] == '0) begin
							push_result(KIND_WAKE, sleeper_tid[i], '0, 1'b0);
							woken++;
							drop_sleeper(i);
							continue;
						end
					end
					i++;
				end
				if (woken > 0) begin
					r = due_results.pop_back();
					r.tail = 1'b1;
					due_results.push_back(r);
				end
			end
			OP_SLEEP: begin
				for (int j = 0; j < SLOTS; j++) begin
					if (sleeper_used[j]) occupied++;
				end
				if (occupied >= SLOTS) begin
					push_result(KIND_FULL, tid, '0, 1'b1);
				end else begin
					for (int j = SLOTS - 1; j > 0; j--) begin
						sleeper_used[j] = sleeper_used[j-1];
						sleeper_tid[j]  = sleeper_tid[j-1];
						sleeper_left[j] = sleeper_left[j-1];
					end
					sleeper_used[0] = 1'b1;
					sleeper_tid[0]  = tid;
					sleeper_left[0] = tk;
				end
			end
			OP_CANCEL: begin
				for (int j = 0; j < SLOTS && !hit; j++) begin
					if (sleeper_used[j] && sleeper_tid[j] == tid) begin
						push_result(KIND_CANCELLED, tid, sleeper_left[j], 1'b1);
						drop_sleeper(j);
						hit = 1'b1;
					end
				end
				if (!hit) begin
					push_result(KIND_NOT_FOUND, tid, '0, 1'b1);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_result();
		wake_result_t r;
		if (due_results.size() == 0) begin
			report($sformatf("result kind %0d thread %0d with nothing expected",
				kind, woken_thread));
		end else begin
			r = due_results.pop_front();
			if (kind !== r.what)
				report($sformatf("kind %0d, expected %0d", kind, r.what));
			if (woken_thread !== r.tid)
				report($sformatf("thread %0d, expected %0d", woken_thread, r.tid));
			if (remaining_ticks !== r.left)
				report($sformatf("remaining %0d, expected %0d", remaining_ticks, r.left));
			if (last !== r.tail)
				report($sformatf("last %0b, expected %0b", last, r.tail));
		end
		case (kind)
			KIND_WAKE:      n_wake++;
			KIND_CANCELLED: n_found++;
			KIND_FULL:      n_full++;
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SLOTS; j++) begin
				sleeper_used[j] = 1'b0;
				sleeper_tid[j]  = '0;
				sleeper_left[j] = '0;
			end
			due_results.delete();
			n_pend  = 0;
			n_req   = 0;
			n_rsp   = 0;
			n_wake  = 0;
			n_found = 0;
			n_full  = 0;
		end else begin
			// A result never belongs to the request taken at the same edge.
			if (rsp_valid && rsp_ready) begin
				check_result();
				n_rsp++;
			end
			if (req_valid && req_ready) begin
				step_sleep_table(operation, thread_id, ticks);
				n_req++;
			end
			n_pend = due_results.size();
		end
	end

endmodule

// ----- test/tb_sleep_timeout_table.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sleep timeout table testbench
// Drives sleep, tick, cancel and unused items into the table with random gaps
// on both channels, and leaves prediction and comparison to the checker that
// sits beside the design. Ends with a verdict taken from its failure count.
// ---------------------------------------------------------------------------
module tb_sleep_timeout_table
	import stt_pkg::*;
();

	// The operation code that the table must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Cycles with no item taken on either channel before the run is abandoned.
	// The longest legitimate quiet spell is the receiver's long hold-off plus
	// one table walk, so this is several times that.
	localparam int IDLE_LIMIT = 3000;

	// Length of the receiver's single long hold-off, in cycles.
	localparam int HOLD_CYCLES = 300;

	localparam int RANDOM_ITEMS = 220;

	// A flood is one more sleeper than the table holds.
	localparam int FLOOD_ITEMS = 17;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  operation;
	logic [7:0]  thread_id;
	logic [31:0] ticks;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [1:0]  kind;
	logic [7:0]  woken_thread;
	logic [31:0] remaining_ticks;
	logic        last;

	int fail_count;
	int pending;
	int req_taken;
	int rsp_taken;
	int wakes_seen;
	int cancels_found;
	int fulls_seen;

	// Stimulus tallies, kept only for the closing summary.
	int n_tick;
	int n_sleep;
	int n_cancel;
	int n_unused;

	// Each side flips between a busy spell with no gaps and a spell of random gaps.
	bit tx_busy;
	bit rx_busy;

	sleep_timeout_table u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.operation       (operation),
		.thread_id       (thread_id),
		.ticks           (ticks),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.kind            (kind),
		.woken_thread    (woken_thread),
		.remaining_ticks (remaining_ticks),
		.last            (last)
	);

	stt_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.operation       (operation),
		.thread_id       (thread_id),
		.ticks           (ticks),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.kind            (kind),
		.woken_thread    (woken_thread),
		.remaining_ticks (remaining_ticks),
		.last            (last),
		.fail_count      (fail_count),
		.pending         (pending),
		.req_taken       (req_taken),
		.rsp_taken       (rsp_taken),
		.wakes_seen      (wakes_seen),
		.cancels_found   (cancels_found),
		.fulls_seen      (fulls_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draws the wait before the next item on one side. Now and then the side
	// switches between a busy spell and an idling spell.
	function automatic int draw_gap(inout bit busy);
		if ($urandom_range(0, 11) == 0) busy = !busy;
		return busy ? 0 : int'($urandom_range(0, 18));
	endfunction

	// Sleep lengths: mostly short so that ticks wake threads, with forever
	// sleepers, the largest count and fully random counts mixed in.
	function automatic logic [31:0] pick_ticks();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return $urandom;
			2:       return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	// Thread ids: a small pool so that cancels find their threads, with the
	// whole range now and then so that every id bit moves.
	function automatic logic [7:0] pick_thread();
		if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 7));
	endfunction

	// Offers one item at a falling edge and holds it, payload unchanged, until
	// the checker has counted it as taken. Inputs change only at falling edges,
	// so the next item may follow straight on with valid kept high.
	task automatic send_item(input logic [1:0] op, input logic [7:0] tid,
			input logic [31:0] tk);
		int gap;
		int seen;
		gap = draw_gap(tx_busy);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		operation = op;
		thread_id = tid;
		ticks     = tk;
		seen      = req_taken;
		do @(negedge clk); while (req_taken == seen);
		case (op)
			OP_TICK:   n_tick++;
			OP_SLEEP:  n_sleep++;
			OP_CANCEL: n_cancel++;
			default:   n_unused++;
		endcase
	endtask

	// Receiver: draws a wait for every result item, and once, well into the
	// random part, holds off for a long stretch while the sender keeps
	// offering, so that the table stalls its walk and then its input.
	initial begin
		int gap;
		int seen;
		bit held;
		held      = 1'b0;
		rsp_ready = 1'b0;
		rx_busy   = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && rsp_taken >= 40) begin
				held      = 1'b1;
				rsp_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = draw_gap(rx_busy);
			if (gap > 0) begin
				rsp_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready = 1'b1;
			seen      = rsp_taken;
			do @(negedge clk); while (rsp_taken == seen);
		end
	end

	// Watchdog: any item taken on either channel restarts the count.
	initial begin
		int idle;
		int moved;
		int was;
		idle = 0;
		was  = 0;
		wait (arst_n);
		while (idle < IDLE_LIMIT) begin
			@(negedge clk);
			moved = req_taken + rsp_taken;
			if (moved != was) idle = 0;
			else idle++;
			was = moved;
		end
		$display("timeout: no item taken for %0d cycles", IDLE_LIMIT);
		$display("sleep_timeout_table test failed");
		$finish;
	end

	initial begin
		int       made;
		int       pick;
		int       burst;
		bit [7:0] tid;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		operation = OP_TICK;
		thread_id = '0;
		ticks     = '0;
		tx_busy   = 1'b0;
		n_tick    = 0;
		n_sleep   = 0;
		n_cancel  = 0;
		n_unused  = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. An empty table: a tick wakes nobody, a cancel finds
		// nothing, and the unused code is ignored.
		send_item(OP_TICK, 8'hA5, 32'h5A5A_5A5A);
		send_item(OP_CANCEL, 8'd0, 32'd0);
		send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);

		// A forever sleeper, the longest sleep, and a duplicate thread id.
		// The tick wakes two threads newest first with last on the second.
		send_item(OP_SLEEP, 8'hFF, 32'd0);
		send_item(OP_SLEEP, 8'd0, 32'hFFFF_FFFF);
		send_item(OP_SLEEP, 8'd5, 32'd1);
		send_item(OP_SLEEP, 8'd6, 32'd1);
		send_item(OP_SLEEP, 8'd5, 32'd2);
		send_item(OP_TICK, 8'd0, 32'd0);

		// Fill the table, refuse one more sleeper, then one tick wakes
		// everything that was one tick from its end.
		repeat (13) send_item(OP_SLEEP, 8'($urandom_range(16, 255)), 32'd1);
		send_item(OP_SLEEP, 8'd77, 32'd9);
		send_item(OP_TICK, 8'd0, 32'd0);

		// Cancels of a forever sleeper, of a long sleeper, and of one gone.
		send_item(OP_CANCEL, 8'hFF, 32'd0);
		send_item(OP_CANCEL, 8'd0, 32'd0);
		send_item(OP_CANCEL, 8'd5, 32'd0);

		// Random part. Mostly sleeps and ticks with short counts so that the
		// table fills and drains, cancels against a small thread pool, and an
		// occasional flood that fills the table and times its sleepers out over
		// two ticks. Ignored items are not counted.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				burst = FLOOD_ITEMS;
				repeat (burst) send_item(OP_SLEEP, 8'($urandom_range(0, 255)),
					$urandom_range(1, 2));
				send_item(OP_TICK, 8'($urandom), $urandom);
				send_item(OP_TICK, 8'($urandom), $urandom);
				made += burst + 2;
			end else if (pick < 45) begin
				tid = pick_thread();
				send_item(OP_SLEEP, tid, tid > 8'd7 ? 32'($urandom_range(1, 6))
					: pick_ticks());
				made++;
			end else if (pick < 72) begin
				send_item(OP_TICK, 8'($urandom), $urandom);
				made++;
			end else if (pick < 95) begin
				send_item(OP_CANCEL, pick_thread(), $urandom);
				made++;
			end else begin
				send_item(OP_UNUSED, 8'($urandom), $urandom);
			end
		end
		req_valid = 1'b0;

		// Drain: a tick that wakes nobody may still be walking once the last
		// result is in, so allow a few table walks more.
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);

		$display("Covered %0d items: %0d ticks, %0d sleeps, %0d cancels, %0d unused codes.",
			req_taken, n_tick, n_sleep, n_cancel, n_unused);
		$display("Checked %0d results: %0d timeouts, %0d cancels found, %0d refused.",
			rsp_taken, wakes_seen, cancels_found, fulls_seen);
		if (fail_count == 0) begin
			$display("sleep_timeout_table test passed");
		end else begin
			$display("sleep_timeout_table test failed");
		end
		$finish;
	end

endmodule
